FILE: hdl/rational_polynomial_multiply_unit_assert.svh
// Assertion macros for the rational polynomial multiply unit
`ifndef RATIONAL_POLYNOMIAL_MULTIPLY_UNIT_ASSERT_SVH
`define RATIONAL_POLYNOMIAL_MULTIPLY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rpm assertion failed");
`define RPM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rpm assertion failed");
`else
`define RPM_ASSERT(lbl, prop)
`define RPM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/rpm_pkg.sv
// Shared constants, types and helpers of the rational polynomial multiply unit
package rpm_pkg;
  localparam int MaxTerms = 16;
  localparam int TermW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int CntW     = $clog2(MaxTerms + 1);
  localparam int FacDepth = 2 * MaxTerms;
  localparam int FacW     = TermW + 1;
  localparam int AccDepth = 2 * MaxTerms - 1;
  localparam int AccW     = (AccDepth > 1) ? $clog2(AccDepth + 1) : 1;
  localparam int PowW     = 5;

  localparam logic [1:0] ErrOk   = 2'd0;
  localparam logic [1:0] ErrZero = 2'd1;
  localparam logic [1:0] ErrOvf  = 2'd2;

  localparam logic CmdFirst  = 1'b0;
  localparam logic CmdSecond = 1'b1;

  typedef enum logic [3:0] {
    SIdle, SDec, SClr, SRdA, SRdB, SRdC, SMpN, SMpD, SRs1, SRw1,
    SMt1, SMt2, SMad, SRs2, SRw2, SOut
  } conv_state_e;

  typedef enum logic [2:0] {
    RIdle, RGcd, RDivN, RDivD
  } red_state_e;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction
endpackage

FILE: hdl/rpm_reduce.sv
// Fraction reduction unit: binary gcd, then restoring division of both parts
module rpm_reduce import rpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic        zero_o,
  output logic [31:0] num_o,
  output logic [31:0] den_o
);
  red_state_e  state_q, state_d;
  logic        done_q, zero_q;
  logic [31:0] n_q, d_q, a_q, b_q, g_q, rem_q, quo_q;
  logic [4:0]  sh_q, bc_q;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_nx, quo_nx, q_signed;
  logic        gcd_end;

  assign gcd_end = (a_q == 32'd0) || (b_q == 32'd0);
  assign rem_sh  = {rem_q, quo_q[31]};
  assign ge      = rem_sh >= {1'b0, g_q};
  assign rem_nx  = ge ? 32'(rem_sh - {1'b0, g_q}) : rem_sh[31:0];
  assign quo_nx  = {quo_q[30:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RIdle: if (start_i && den_i != 32'd0) state_d = RGcd;
      RGcd:  if (gcd_end) state_d = RDivN;
      RDivN: if (bc_q == 5'd31) state_d = RDivD;
      RDivD: if (bc_q == 5'd31) state_d = RIdle;
      default: state_d = RIdle;
    endcase
  end

  always_comb begin
    q_signed = quo_nx;
    unique case (state_q)
      RDivN: if (n_q[31] ^ g_q[31]) q_signed = 32'd0 - quo_nx;
      RDivD: if (d_q[31] ^ g_q[31]) q_signed = 32'd0 - quo_nx;
      default: q_signed = quo_nx;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RIdle;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == RIdle && start_i && den_i == 32'd0) ||
                 (state_q == RDivD && bc_q == 5'd31);
      if (state_q == RIdle && start_i) zero_q <= (den_i == 32'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      RIdle: begin
        n_q  <= num_i;
        d_q  <= den_i;
        a_q  <= mag32(num_i);
        b_q  <= mag32(den_i);
        sh_q <= 5'd0;
      end
      RGcd: begin
        if (gcd_end) begin
          g_q   <= (a_q | b_q) << sh_q;
          rem_q <= 32'd0;
          quo_q <= mag32(n_q);
          bc_q  <= 5'd0;
        end else if (!a_q[0] && !b_q[0]) begin
          a_q  <= a_q >> 1;
          b_q  <= b_q >> 1;
          sh_q <= sh_q + 5'd1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q >= b_q) begin
          a_q <= a_q - b_q;
        end else begin
          b_q <= b_q - a_q;
        end
      end
      RDivN: begin
        bc_q <= bc_q + 5'd1;
        if (bc_q == 5'd31) begin
          n_q   <= q_signed;
          rem_q <= 32'd0;
          quo_q <= mag32(d_q);
        end else begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
        end
      end
      RDivD: begin
        bc_q  <= bc_q + 5'd1;
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        if (bc_q == 5'd31) begin
          if (q_signed[31]) begin
            n_q <= 32'd0 - n_q;
            d_q <= 32'd0 - q_signed;
          end else begin
            d_q <= q_signed;
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign zero_o = zero_q;
  assign num_o  = n_q;
  assign den_o  = d_q;
endmodule

FILE: hdl/rational_polynomial_multiply_unit.sv
// Rational polynomial multiply unit: factor and accumulator memories with convolution sequencer
// Load words are taken one per cycle; busy stays low while factors are loaded. The final
// second-factor word starts the product: a decode state, a clear sweep of the accumulator,
// then per term pair the memory reads and multiplies plus two passes of the reduction
// unit, each a binary gcd followed by restoring division. The first coefficient is read in
// the output state after the last accumulator write and leaves through the read and output
// registers, then one per cycle. An error or an empty product gives a single word in the
// cycle after it is found. Results leave on valid_o for one cycle each and cannot be
// stalled; busy falls in the cycle that carries the last result.
`include "rational_polynomial_multiply_unit_assert.svh"
module rational_polynomial_multiply_unit import rpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic signed [31:0] coef_numerator_i,
  input  logic signed [31:0] coef_denominator_i,
  input  logic               final_term_i,
  output logic               valid_o,
  output logic signed [31:0] prod_numerator_o,
  output logic [30:0]        prod_denominator_o,
  output logic [PowW-1:0]    power_index_o,
  output logic               run_end_o,
  output logic [1:0]         error_code_o
);
  conv_state_e state_q, state_d;
  logic [CntW-1:0]  fc_q, fc_d, sc_q, sc_d;
  logic             cmp_q, cmp_d, ovf_q, ovf_d;
  logic [TermW-1:0] i_q, j_q;
  logic [AccW-1:0]  cnt_q, total_q, k;

  logic [63:0] fac_mem [FacDepth];
  logic [63:0] acc_mem [AccDepth];
  logic [63:0] fac_rd_q, acc_rd_q, fac_wd, acc_wd;
  logic [FacW-1:0] fac_wa, fac_ra;
  logic [AccW-1:0] acc_wa, acc_ra;
  logic            fac_we, acc_we;

  logic [31:0] fa_n_q, fa_d_q, fb_n_q, fb_d_q, ac_n_q, ac_d_q;
  logic [31:0] mul_q, ma, mb, pn_q, rpn_q, rpd_q, t1_q, an_q;
  logic        red_start, red_done, red_zero;
  logic [31:0] red_n, red_d, red_ni, red_di;
  logic        accept, last_i, last_j;
  logic [CntW-1:0] fbase;

  logic            rdv_q, rdlast_q;
  logic [PowW-1:0] rdpow_q;
  logic            valid_q, valid_d, olast_q, olast_d;
  logic [31:0]     onum_q, onum_d;
  logic [30:0]     oden_q, oden_d;
  logic [PowW-1:0] opow_q, opow_d;
  logic [1:0]      oerr_q, oerr_d;

  assign accept = start && !busy;
  assign k      = AccW'(i_q) + AccW'(j_q);
  assign last_i = ({1'b0, i_q} == (TermW + 1)'(fc_q - CntW'(1)));
  assign last_j = ({1'b0, j_q} == (TermW + 1)'(sc_q - CntW'(1)));
  assign fbase  = cmp_q ? CntW'(0) : fc_q;

  rpm_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .num_i   (red_ni),
    .den_i   (red_di),
    .done_o  (red_done),
    .zero_o  (red_zero),
    .num_o   (red_n),
    .den_o   (red_d)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (accept && command_i == CmdSecond && final_term_i) state_d = SDec;
      SDec: begin
        if (ovf_q || fc_q == CntW'(0)) state_d = SIdle;
        else state_d = SClr;
      end
      SClr: if (cnt_q == total_q - AccW'(1)) state_d = SRdA;
      SRdA: state_d = SRdB;
      SRdB: state_d = SRdC;
      SRdC: state_d = SMpN;
      SMpN: state_d = SMpD;
      SMpD: state_d = SRs1;
      SRs1: state_d = SRw1;
      SRw1: begin
        if (red_done) state_d = red_zero ? SIdle : SMt1;
      end
      SMt1: state_d = SMt2;
      SMt2: state_d = SMad;
      SMad: state_d = SRs2;
      SRs2: state_d = SRw2;
      SRw2: begin
        if (red_done) begin
          if (red_zero) state_d = SIdle;
          else if (last_i && last_j) state_d = SOut;
          else state_d = SRdA;
        end
      end
      SOut: if (cnt_q == total_q - AccW'(1)) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    busy      = (state_q != SIdle) || rdv_q;
    fac_we    = 1'b0;
    fac_wa    = {command_i, TermW'(command_i ? sc_q : fbase)};
    fac_wd    = {coef_numerator_i, coef_denominator_i};
    fac_ra    = {1'b0, i_q};
    acc_we    = 1'b0;
    acc_wa    = cnt_q;
    acc_wd    = {32'd0, 32'd1};
    acc_ra    = k;
    red_start = 1'b0;
    red_ni    = pn_q;
    red_di    = mul_q;
    ma        = fa_n_q;
    mb        = fb_n_q;
    fc_d      = fc_q;
    sc_d      = sc_q;
    cmp_d     = cmp_q;
    ovf_d     = ovf_q;
    unique case (state_q)
      SIdle: begin
        acc_ra = cnt_q;
        if (accept) begin
          if (command_i == CmdFirst) begin
            if (cmp_q) begin
              sc_d  = CntW'(0);
              ovf_d = 1'b0;
              cmp_d = 1'b0;
            end
            if (fbase < CntW'(MaxTerms)) begin
              fac_we = 1'b1;
              fc_d   = fbase + CntW'(1);
            end else begin
              fc_d  = fbase;
              ovf_d = 1'b1;
            end
            if (final_term_i) cmp_d = 1'b1;
          end else begin
            if (sc_q < CntW'(MaxTerms)) begin
              fac_we = 1'b1;
              sc_d   = sc_q + CntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      SClr: acc_we = 1'b1;
      SRdB: fac_ra = {1'b1, j_q};
      SMpD: begin
        ma = fa_d_q;
        mb = fb_d_q;
      end
      SRs1: red_start = 1'b1;
      SMt1: begin
        ma = ac_n_q;
        mb = rpd_q;
      end
      SMt2: begin
        ma = rpn_q;
        mb = ac_d_q;
      end
      SMad: begin
        ma = ac_d_q;
        mb = rpd_q;
      end
      SRs2: begin
        red_start = 1'b1;
        red_ni    = an_q;
      end
      SRw2: begin
        acc_wa = k;
        acc_wd = {red_n, red_d};
        acc_we = red_done && !red_zero;
      end
      SOut: acc_ra = cnt_q;
      default: ;
    endcase
    if (state_d == SIdle && state_q != SIdle) begin
      fc_d  = CntW'(0);
      sc_d  = CntW'(0);
      cmp_d = 1'b0;
      ovf_d = 1'b0;
    end
  end

  always_comb begin
    valid_d = 1'b0;
    onum_d  = onum_q;
    oden_d  = oden_q;
    opow_d  = opow_q;
    olast_d = olast_q;
    oerr_d  = oerr_q;
    if (rdv_q) begin
      valid_d = 1'b1;
      onum_d  = acc_rd_q[63:32];
      oden_d  = acc_rd_q[30:0];
      opow_d  = rdpow_q;
      olast_d = rdlast_q;
      oerr_d  = ErrOk;
    end
    if (state_q == SDec && (ovf_q || fc_q == CntW'(0))) begin
      valid_d = 1'b1;
      onum_d  = 32'd0;
      oden_d  = ovf_q ? 31'd0 : 31'd1;
      opow_d  = '0;
      olast_d = 1'b1;
      oerr_d  = ovf_q ? ErrOvf : ErrOk;
    end
    if ((state_q == SRw1 || state_q == SRw2) && red_done && red_zero) begin
      valid_d = 1'b1;
      onum_d  = 32'd0;
      oden_d  = 31'd0;
      opow_d  = '0;
      olast_d = 1'b1;
      oerr_d  = ErrZero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fac_we) fac_mem[fac_wa] <= fac_wd;
    fac_rd_q <= fac_mem[fac_ra];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk_i) begin
    mul_q <= ma * mb;
    case (state_q)
      SRdB: {fa_n_q, fa_d_q} <= fac_rd_q;
      SRdC: begin
        {fb_n_q, fb_d_q} <= fac_rd_q;
        {ac_n_q, ac_d_q} <= acc_rd_q;
      end
      SMpD: pn_q <= mul_q;
      SRw1: begin
        rpn_q <= red_n;
        rpd_q <= red_d;
      end
      SMt2: t1_q <= mul_q;
      SMad: an_q <= t1_q + mul_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      fc_q     <= '0;
      sc_q     <= '0;
      cmp_q    <= 1'b0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      total_q  <= '0;
      rdv_q    <= 1'b0;
      rdpow_q  <= '0;
      rdlast_q <= 1'b0;
      valid_q  <= 1'b0;
      onum_q   <= '0;
      oden_q   <= '0;
      opow_q   <= '0;
      olast_q  <= 1'b0;
      oerr_q   <= ErrOk;
    end else begin
      state_q  <= state_d;
      fc_q     <= fc_d;
      sc_q     <= sc_d;
      cmp_q    <= cmp_d;
      ovf_q    <= ovf_d;
      rdv_q    <= (state_q == SOut);
      rdpow_q  <= PowW'(cnt_q);
      rdlast_q <= (cnt_q == total_q - AccW'(1));
      valid_q  <= valid_d;
      onum_q   <= onum_d;
      oden_q   <= oden_d;
      opow_q   <= opow_d;
      olast_q  <= olast_d;
      oerr_q   <= oerr_d;
      if (state_q == SDec) begin
        cnt_q   <= '0;
        total_q <= AccW'(fc_q) + AccW'(sc_q) - AccW'(1);
        i_q     <= '0;
        j_q     <= '0;
      end
      if (state_q == SClr || state_q == SOut) cnt_q <= cnt_q + AccW'(1);
      if (state_q == SRw2 && red_done && !red_zero) begin
        if (last_j) begin
          j_q <= '0;
          if (last_i) cnt_q <= '0;
          else i_q <= i_q + TermW'(1);
        end else begin
          j_q <= j_q + TermW'(1);
        end
      end
    end
  end

  assign valid_o            = valid_q;
  assign run_end_o          = olast_q;
  assign error_code_o       = oerr_q;
  assign prod_numerator_o   = onum_q;
  assign prod_denominator_o = oden_q;
  assign power_index_o      = opow_q;

  `RPM_ASSERT(a_valid_known, !$isunknown(valid_o))
  `RPM_ASSERT(a_state_known, !$isunknown(state_q))
  `RPM_ASSERT(a_error_ends_run, valid_o && error_code_o != ErrOk |-> run_end_o)
  `RPM_ASSERT(a_error_zero_den, valid_o && error_code_o != ErrOk |-> prod_denominator_o == '0)
endmodule
